FILE: sv/ebd_pkg.sv
package ebd_pkg;

  localparam int MAX_LINE_WORDS = 2048;
  localparam int COL_W = $clog2(MAX_LINE_WORDS);
  localparam int ROW_LIMIT = 2048;
  localparam int ROW_W = $clog2(ROW_LIMIT);
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_W = 12;
  localparam int THR_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

  localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 12'd720;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd576;
  localparam logic [CFG_W-1:0] RST_EDGE_WEIGHT  = 12'd625;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 16'd73;

  localparam int SQ_SHIFT = 12;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic emit;
    logic filter;
    logic frame_end;
    logic store;
  } ebd_ctl_t;

endpackage

FILE: sv/ebd_in_if.sv
interface ebd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] luma_in;
  logic [7:0] chroma_in;

  modport source (output valid, output opcode, output luma_in, output chroma_in, input ready);
  modport sink (input valid, input opcode, input luma_in, input chroma_in, output ready);
endinterface

FILE: sv/ebd_out_if.sv
interface ebd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic [7:0] chroma_out;
  logic       interpolated;
  logic       frame_end;

  modport source (output valid, output luma_out, output chroma_out, output interpolated,
                  output frame_end, input ready);
  modport sink (input valid, input luma_out, input chroma_out, input interpolated,
                input frame_end, output ready);
endinterface

FILE: sv/ebd_ram.sv
module ebd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ebd_filter.sv
module ebd_filter (
  input  logic                        clk,
  input  logic                        load,
  input  logic [ebd_pkg::WORD_W-1:0]  above,
  input  logic [ebd_pkg::WORD_W-1:0]  centre,
  input  logic [ebd_pkg::WORD_W-1:0]  below,
  input  logic [ebd_pkg::CFG_W-1:0]   weight,
  input  logic [ebd_pkg::THR_W-1:0]   threshold,
  output logic                        interp,
  output logic [ebd_pkg::WORD_W-1:0]  result
);
  import ebd_pkg::*;

  logic signed [7:0]  ae;
  logic signed [7:0]  be;
  logic signed [7:0]  d;
  logic signed [15:0] prod;
  logic signed [15:0] dsq;
  logic [BYTE_W-1:0]  avg_lo;
  logic [BYTE_W-1:0]  avg_hi;

  logic signed [15:0]    prod_r;
  logic [1:0]            q_r;
  logic [WORD_W-1:0]     avg_r;
  logic [WORD_W-1:0]     centre_r;

  logic [CFG_W+1:0]      wq;
  logic signed [16:0]    metric;
  logic signed [16:0]    thr_ext;

  assign ae = $signed({1'b0, above[7:1]}) - $signed({1'b0, centre[7:1]});
  assign be = $signed({1'b0, below[7:1]}) - $signed({1'b0, centre[7:1]});
  assign d  = $signed({1'b0, above[7:1]}) - $signed({1'b0, below[7:1]});
  assign prod = 16'(ae) * 16'(be);
  assign dsq  = 16'(d) * 16'(d);

  assign avg_lo = {1'b0, above[7:1]} + {1'b0, below[7:1]};
  assign avg_hi = {1'b0, above[15:9]} + {1'b0, below[15:9]};

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r   <= prod;
      q_r      <= dsq[SQ_SHIFT+1:SQ_SHIFT];
      avg_r    <= {avg_hi, avg_lo};
      centre_r <= centre;
    end
  end

  assign wq      = (CFG_W+2)'(weight) * (CFG_W+2)'(q_r);
  assign metric  = $signed({prod_r[15], prod_r}) - $signed({1'b0, {(16-CFG_W-2){1'b0}}, wq});
  assign thr_ext = $signed({threshold[THR_W-1], threshold});
  assign interp  = metric > thr_ext;
  assign result  = interp ? avg_r : centre_r;

endmodule

FILE: sv/edge_adaptive_bob_deinterlacer.sv
// edge-adaptive bob deinterlacer for a packed luma/chroma word stream
// in_chan: one request per word, opcode 0 carries a pixel (luma low byte,
//   chroma high byte) in raster order, opcode 1 flushes one word of the
//   last line of a frame
// out_chan: at most one request per accepted word, the output runs one
//   line behind the input; frame_end marks the last flushed word
// cfg_*: register writes, to be issued only while the block is idle
// each word passes through a line store read, a read-modify-write of both
//   line stores with the first filter stage, and a metric compare, which
//   loads the result into the output register
// a new word is accepted only after the last leaves the compare step,
//   set by the single read port and write-back to the same line store entry
// a stalled receiver holds the output register; the next word is still
//   accepted and processed, and waits in the compare cycle until the
//   output register frees up
// reset clears counters, flush state and registers to their defaults;
//   the line stores are not cleared and hold whatever was last written
module edge_adaptive_bob_deinterlacer (
  input  logic                            clk,
  input  logic                            rst_n,
  ebd_in_if.sink                          in_chan,
  ebd_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ebd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ebd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ebd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RMW, ST_EVAL} state_t;

  state_t state_r;

  logic [CFG_W-1:0] width_cfg_r;
  logic [CFG_W-1:0] height_cfg_r;
  logic [CFG_W-1:0] weight_r;
  logic [THR_W-1:0] thr_r;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             pending_r;

  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             pending_nxt;

  logic [COL_W-1:0]  idx_r;
  logic [WORD_W-1:0] word_r;
  ebd_ctl_t          ctl_r;
  ebd_ctl_t          ctl_nxt;

  logic [WORD_W-1:0] prev_rd;
  logic [WORD_W-1:0] two_rd;

  logic              accept;
  logic              last_col;
  logic              last_row;
  logic [CMP_W-1:0]  w_now;
  logic [HCMP_W-1:0] h_now;
  logic [WORD_W-1:0] in_word;

  logic              filt_interp;
  logic [WORD_W-1:0] filt_word;
  logic              load_out;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_interp_r;
  logic              out_fend_r;

  assign in_word = {in_chan.chroma_in, in_chan.luma_in};
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    w_now = CMP_W'(width_cfg_r);
    if (w_now == '0) begin
      w_now = CMP_W'(1);
    end else if (w_now > CMP_W'(MAX_LINE_WORDS)) begin
      w_now = CMP_W'(MAX_LINE_WORDS);
    end
    h_now = HCMP_W'(height_cfg_r);
    if (h_now < HCMP_W'(2)) begin
      h_now = HCMP_W'(2);
    end else if (h_now > HCMP_W'(ROW_LIMIT)) begin
      h_now = HCMP_W'(ROW_LIMIT);
    end
  end

  assign last_col = (CMP_W'(col_r) + CMP_W'(1)) >= w_now;
  assign last_row = (HCMP_W'(row_r) + HCMP_W'(1)) >= h_now;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pending_nxt = pending_r;
    ctl_nxt     = '0;
    if (in_chan.opcode == OP_FLUSH) begin
      if (pending_r) begin
        ctl_nxt.emit      = 1'b1;
        ctl_nxt.frame_end = last_col;
        if (last_col) begin
          pending_nxt = 1'b0;
          col_nxt     = '0;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end else begin
      ctl_nxt.store = 1'b1;
      if (row_r == '0) begin
        ctl_nxt.emit      = pending_r;
        ctl_nxt.frame_end = last_col;
        if (last_col) begin
          pending_nxt = 1'b0;
        end
      end else begin
        ctl_nxt.emit   = 1'b1;
        ctl_nxt.filter = row_r[0] && (row_r >= ROW_W'(3));
      end
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt     = '0;
          pending_nxt = 1'b1;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  ebd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LINE_WORDS)) u_prev_ram (
    .clk   (clk),
    .we    ((state_r == ST_RMW) && ctl_r.store),
    .waddr (idx_r),
    .wdata (word_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (prev_rd)
  );

  ebd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LINE_WORDS)) u_two_ram (
    .clk   (clk),
    .we    ((state_r == ST_RMW) && ctl_r.store),
    .waddr (idx_r),
    .wdata (prev_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (two_rd)
  );

  ebd_filter u_filter (
    .clk       (clk),
    .load      (state_r == ST_RMW),
    .above     (two_rd),
    .centre    (prev_rd),
    .below     (word_r),
    .weight    (weight_r),
    .threshold (thr_r),
    .interp    (filt_interp),
    .result    (filt_word)
  );

  assign load_out = (state_r == ST_EVAL) && ctl_r.emit && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      pending_r    <= 1'b0;
      ctl_r        <= '0;
      out_valid_r  <= 1'b0;
      width_cfg_r  <= RST_LINE_WIDTH;
      height_cfg_r <= RST_FRAME_HEIGHT;
      weight_r     <= RST_EDGE_WEIGHT;
      thr_r        <= RST_THRESHOLD;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_WIDTH:   width_cfg_r  <= cfg_data[CFG_W-1:0];
          CFG_FRAME_HEIGHT: height_cfg_r <= cfg_data[CFG_W-1:0];
          CFG_EDGE_WEIGHT:  weight_r     <= cfg_data[CFG_W-1:0];
          CFG_THRESHOLD:    thr_r        <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_word_r   <= (ctl_r.filter && filt_interp) ? filt_word : prev_rd;
        out_interp_r <= ctl_r.filter && filt_interp;
        out_fend_r   <= ctl_r.frame_end;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            col_r     <= col_nxt;
            row_r     <= row_nxt;
            pending_r <= pending_nxt;
            ctl_r     <= ctl_nxt;
            idx_r     <= col_r;
            word_r    <= in_word;
            state_r   <= ST_RMW;
          end
        end
        ST_RMW: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!ctl_r.emit || load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.luma_out     = out_word_r[7:0];
  assign out_chan.chroma_out   = out_word_r[15:8];
  assign out_chan.interpolated = out_interp_r;
  assign out_chan.frame_end    = out_fend_r;

endmodule

FILE: tb/tb.sv
typedef struct {
  logic [7:0] luma;
  logic [7:0] chroma;
  logic       interpolated;
  logic       frame_end;
} deint_word_t;

class deint_scoreboard;
  logic [15:0] prev_row [ebd_pkg::MAX_LINE_WORDS];
  logic [15:0] prev2_row [ebd_pkg::MAX_LINE_WORDS];
  int unsigned col_idx;
  int unsigned row_idx;
  bit          flush_pending;
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [11:0] weight_reg;
  logic [15:0] thr_reg;
  deint_word_t expected_words [$];
  int          errors;

  function new();
    width_reg = ebd_pkg::RST_LINE_WIDTH;
    height_reg = ebd_pkg::RST_FRAME_HEIGHT;
    weight_reg = ebd_pkg::RST_EDGE_WEIGHT;
    thr_reg = ebd_pkg::RST_THRESHOLD;
    col_idx = 0;
    row_idx = 0;
    flush_pending = 1'b0;
    errors = 0;
  endfunction

  function void write_register(logic [ebd_pkg::CFG_IDX_W-1:0] idx,
                               logic [ebd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ebd_pkg::CFG_LINE_WIDTH: width_reg = data[11:0];
      ebd_pkg::CFG_FRAME_HEIGHT: height_reg = data[11:0];
      ebd_pkg::CFG_EDGE_WEIGHT: weight_reg = data[11:0];
      ebd_pkg::CFG_THRESHOLD: thr_reg = data;
    endcase
  endfunction

  function int unsigned words_for(logic [11:0] w);
    if (w < 1) return 1;
    if (w > ebd_pkg::MAX_LINE_WORDS) return ebd_pkg::MAX_LINE_WORDS;
    return 32'(w);
  endfunction

  function int unsigned line_words();
    return words_for(width_reg);
  endfunction

  function int unsigned frame_rows();
    if (height_reg < 2) return 2;
    if (height_reg > ebd_pkg::ROW_LIMIT) return ebd_pkg::ROW_LIMIT;
    return 32'(height_reg);
  endfunction

  function logic [15:0] edge_filter(logic [15:0] above, logic [15:0] centre,
                                    logic [15:0] below, output logic interp);
    int      a;
    int      e;
    int      b;
    int      d;
    int      metric;
    shortint thr;
    a = int'(above[7:0] >> 1);
    e = int'(centre[7:0] >> 1);
    b = int'(below[7:0] >> 1);
    d = a - b;
    metric = (a - e) * (b - e) - int'(weight_reg) * ((d * d) >>> ebd_pkg::SQ_SHIFT);
    thr = thr_reg;
    if (metric > int'(thr)) begin
      interp = 1'b1;
      return ((above & 16'hfefe) >> 1) + ((below & 16'hfefe) >> 1);
    end
    interp = 1'b0;
    return centre;
  endfunction

  function void push_word(logic [15:0] word, logic interp, logic fend);
    deint_word_t w;
    w.luma = word[7:0];
    w.chroma = word[15:8];
    w.interpolated = interp;
    w.frame_end = fend;
    expected_words.push_back(w);
  endfunction

  // returns 0 when the request is ignored
  function bit note_request(logic op, logic [7:0] luma, logic [7:0] chroma);
    int unsigned idx;
    bit          last_col;
    logic [15:0] word;
    logic [15:0] res;
    logic        interp;
    idx = col_idx % ebd_pkg::MAX_LINE_WORDS;
    last_col = (col_idx + 1) >= line_words();
    word = {chroma, luma};
    if (op == ebd_pkg::OP_FLUSH) begin
      if (!flush_pending) return 0;
      push_word(prev_row[idx], 1'b0, last_col);
      if (last_col) begin
        flush_pending = 1'b0;
        col_idx = 0;
      end else begin
        col_idx++;
      end
      return 1;
    end
    if (row_idx == 0) begin
      if (flush_pending) begin
        push_word(prev_row[idx], 1'b0, last_col);
        if (last_col) flush_pending = 1'b0;
      end
    end else begin
      interp = 1'b0;
      res = prev_row[idx];
      if ((row_idx % 2) == 1 && row_idx >= 3)
        res = edge_filter(prev2_row[idx], prev_row[idx], word, interp);
      push_word(res, interp, 1'b0);
    end
    prev2_row[idx] = prev_row[idx];
    prev_row[idx] = word;
    if (last_col) begin
      col_idx = 0;
      if (row_idx + 1 >= frame_rows()) begin
        row_idx = 0;
        flush_pending = 1'b1;
      end else begin
        row_idx++;
      end
    end else begin
      col_idx++;
    end
    return 1;
  endfunction

  function void check_word(logic [7:0] luma, logic [7:0] chroma, logic interp, logic fend);
    deint_word_t want;
    if (expected_words.size() == 0) begin
      $error("output word with no request waiting: luma_out %h chroma_out %h", luma, chroma);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (luma !== want.luma) begin
      $error("luma_out: expected %h, got %h", want.luma, luma);
      errors++;
    end
    if (chroma !== want.chroma) begin
      $error("chroma_out: expected %h, got %h", want.chroma, chroma);
      errors++;
    end
    if (interp !== want.interpolated) begin
      $error("interpolated: expected %b, got %b", want.interpolated, interp);
      errors++;
    end
    if (fend !== want.frame_end) begin
      $error("frame_end: expected %b, got %b", want.frame_end, fend);
      errors++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb;
  import ebd_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int EXTREME_ITEMS = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ebd_in_if  in_chan ();
  ebd_out_if out_chan ();

  edge_adaptive_bob_deinterlacer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deint_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;
  int active_items;
  int cycles;
  bit comb_style;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("edge_adaptive_bob_deinterlacer test failed");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        sb.check_word(out_chan.luma_out, out_chan.chroma_out, out_chan.interpolated,
                      out_chan.frame_end);
      if (hold_asks != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] luma, input logic [7:0] chroma);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= op;
    in_chan.luma_in <= luma;
    in_chan.chroma_in <= chroma;
    do @(posedge clk); while (!in_chan.ready);
    if (sb.note_request(op, luma, chroma)) active_items++;
  endtask

  task automatic send_pixel();
    logic [7:0] l;
    if (comb_style && $urandom_range(99) < 85) begin
      // alternate bright and dark rows to provoke the edge metric
      l = 8'($urandom_range(0, 40));
      l = l + (((sb.row_idx % 2) == 1) ? 8'd190 : 8'd50);
    end else begin
      l = 8'($urandom_range(0, 255));
    end
    send_word(OP_PIXEL, l, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_flush();
    send_word(OP_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // run to the frame boundary and empty the held line
  task automatic complete_frame();
    while (sb.row_idx != 0 || sb.col_idx != 0 || sb.flush_pending) begin
      if (sb.flush_pending) send_flush();
      else send_pixel();
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] spare_bits();
    return ($urandom_range(99) < 20) ? 4'($urandom_range(1, 15)) : 4'd0;
  endfunction

  task automatic directed_checks();
    write_reg(CFG_LINE_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'd5);
    write_reg(CFG_EDGE_WEIGHT, 16'd0);
    write_reg(CFG_THRESHOLD, 16'h8000);
    end_writes();
    // flush with nothing held
    send_word(OP_FLUSH, 8'hff, 8'hff);
    send_word(OP_PIXEL, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'hff, 8'hff);
    send_word(OP_PIXEL, 8'hff, 8'h00);
    send_word(OP_PIXEL, 8'h00, 8'hff);
    send_word(OP_PIXEL, 8'h80, 8'h7f);
    send_word(OP_PIXEL, 8'h01, 8'hfe);
    send_word(OP_PIXEL, 8'hfe, 8'h01);
    send_word(OP_PIXEL, 8'h7f, 8'h80);
    send_word(OP_PIXEL, 8'h55, 8'haa);
    send_word(OP_PIXEL, 8'haa, 8'h55);
    // odd height: last row held, then a row-0 pixel takes a flush slot
    send_word(OP_FLUSH, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'h33, 8'hcc);
    settle();
    write_reg(CFG_EDGE_WEIGHT, 16'h0fff);
    write_reg(CFG_THRESHOLD, 16'h7fff);
    end_writes();
    complete_frame();
  endtask

  task automatic new_settings();
    logic [11:0] w;
    logic [11:0] h;
    logic [11:0] wt;
    logic [15:0] thr;
    bit          do_w;
    bit          do_h;
    bit          do_wt;
    bit          do_thr;
    int          r;
    r = $urandom_range(99);
    w = 12'((r < 60) ? $urandom_range(1, 8) : (r < 85) ? $urandom_range(9, 24) :
            (r < 95) ? $urandom_range(25, 64) : $urandom_range(0, 1));
    r = $urandom_range(99);
    h = 12'((r < 70) ? $urandom_range(2, 8) : (r < 92) ? $urandom_range(9, 20) :
            $urandom_range(0, 1));
    r = $urandom_range(99);
    wt = 12'((r < 50) ? $urandom_range(0, 8) : (r < 85) ? $urandom_range(0, 4095) :
             (r < 93) ? 0 : 4095);
    r = $urandom_range(99);
    if (r < 50) thr = 16'($urandom_range(0, 600)) - 16'd300;
    else if (r < 80) thr = 16'($urandom_range(0, 65535));
    else if (r < 90) thr = 16'h8000;
    else thr = 16'h7fff;
    do_w = ($urandom_range(99) < 60);
    do_h = ($urandom_range(99) < 60);
    do_wt = ($urandom_range(99) < 60);
    do_thr = ($urandom_range(99) < 60);
    // a wider line would read columns never stored
    if ((do_w && sb.words_for(w) > sb.line_words()) || $urandom_range(99) < 30)
      complete_frame();
    settle();
    if (do_w) write_reg(CFG_LINE_WIDTH, {spare_bits(), w});
    if (do_h) write_reg(CFG_FRAME_HEIGHT, {spare_bits(), h});
    if (do_wt) write_reg(CFG_EDGE_WEIGHT, {spare_bits(), wt});
    if (do_thr) write_reg(CFG_THRESHOLD, thr);
    end_writes();
  endtask

  task automatic run_burst(input int n);
    int r;
    comb_style = 1'($urandom_range(1));
    repeat (n) begin
      r = $urandom_range(99);
      if (sb.flush_pending && r < 45) send_flush();
      else if (!sb.flush_pending && r < 4) send_flush();
      else send_pixel();
    end
  endtask

  task automatic extreme_sizes();
    complete_frame();
    settle();
    write_reg(CFG_LINE_WIDTH, 16'h0fff);
    write_reg(CFG_FRAME_HEIGHT, 16'h0000);
    end_writes();
    repeat (EXTREME_ITEMS) send_pixel();
    settle();
    // narrowing mid-line ends the line on the next request
    write_reg(CFG_LINE_WIDTH, 16'd3);
    end_writes();
    complete_frame();
    settle();
    write_reg(CFG_LINE_WIDTH, 16'h0000);
    write_reg(CFG_FRAME_HEIGHT, 16'h0fff);
    end_writes();
    repeat (EXTREME_ITEMS) send_pixel();
    settle();
    // lowering the height ends the frame on the next request
    write_reg(CFG_FRAME_HEIGHT, 16'd4);
    end_writes();
    complete_frame();
  endtask

  initial begin : stimulus
    sb = new();
    hold_asks = 0;
    active_items = 0;
    comb_style = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 68;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.opcode <= OP_PIXEL;
    in_chan.luma_in <= '0;
    in_chan.chroma_in <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    while (active_items < RANDOM_ITEMS) begin
      if (active_items < 600) begin
        send_idle_pct = 28;
        recv_idle_pct = 68;
      end else if (active_items < 1200) begin
        send_idle_pct = 68;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (hold_asks == 0 && active_items >= 300) hold_asks++;
      if (hold_asks == 1 && active_items >= 1500) hold_asks++;
      new_settings();
      run_burst($urandom_range(10, 60));
    end
    extreme_sizes();
    complete_frame();
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("edge_adaptive_bob_deinterlacer test passed");
    end else begin
      $display("edge_adaptive_bob_deinterlacer test failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/ebd_pkg.sv
sv/ebd_in_if.sv
sv/ebd_out_if.sv
sv/ebd_ram.sv
sv/ebd_filter.sv
sv/edge_adaptive_bob_deinterlacer.sv
tb/tb.sv
